// ----- sv/run_repaint_color_histogram_unit_assert.svh -----
// Assertion macros for the run repaint color histogram unit.
// Used by the top level; has no other dependencies.
`ifndef RUN_REPAINT_COLOR_HISTOGRAM_UNIT_ASSERT_SVH
`define RUN_REPAINT_COLOR_HISTOGRAM_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, switched off while reset is high.
`define RRCH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rrch assertion failed");
// Checked property that also holds through reset.
`define RRCH_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rrch assertion failed");
`else
`define RRCH_ASSERT(lbl, clk, rst, prop)
`define RRCH_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- sv/rrch_pkg.sv -----
// Shared types and constants of the run repaint color histogram unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rrch_pkg;
   localparam int CELL_W  = 10;
   localparam int COLOR_W = 10;
   localparam int COUNT_W = 11;
   localparam int RESET_CELLS = 1024;

   localparam logic CMD_PAINT = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_SRCH, ST_HEAD_RD, ST_HEAD_DAT, ST_TOLD_RD, ST_TOLD_WR,
      ST_TNEW_RD, ST_TNEW_WR, ST_LEFT_RD, ST_LEFT_DAT, ST_RIGHT_CHK, ST_RIGHT_RD,
      ST_RIGHT_DAT, ST_Q_RD, ST_Q_DAT
   } rrch_state_type;

   typedef enum logic [2:0] {
      ALU_ADD, ALU_SUB, ALU_SUBINC, ALU_DEC, ALU_INC
   } rrch_alu_op_type;
endpackage
`default_nettype wire

// ----- sv/run_repaint_color_histogram_unit.sv -----
// Run repaint color histogram unit: run memories, tally memory, sequencer.
// Depends on rrch_pkg and run_repaint_color_histogram_unit_assert.svh.
//
// Usage: the req_ channel carries paint and query commands; the rsp_ channel
// returns one count per query, none per paint. csr_wr_en with csr_wr_data sets
// the cell count and restarts the row. req_stall is high while a command is
// being worked on, so commands are taken one at a time.
// Timing: rsp_valid rises after a query's transfer, once ST_Q_RD and ST_Q_DAT
// have passed and the result register is free. A paint of a cell outside the
// row is taken and dropped. A paint walks back to find the run start, twice
// (its own run and the left neighbor run); the walk steps through the start-mark
// memory one read a cycle, and one shared adder does the paint arithmetic.
// Reset and every cell-count write start a clearing pass over max(MAX_CELLS,1024)
// entries that rewrites all memories, one entry a cycle; commands are stalled
// during it. The result register holds a count while rsp_stall is high, and
// the block keeps taking paints meanwhile; a query waits for the register.
`timescale 1ns / 1ps
`default_nettype none
`include "run_repaint_color_histogram_unit_assert.svh"
module run_repaint_color_histogram_unit #(
   parameter int MAX_CELLS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_command,
   input  wire logic [rrch_pkg::CELL_W-1:0]  req_cell_req,
   input  wire logic [rrch_pkg::COLOR_W-1:0] req_color,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [rrch_pkg::COUNT_W-1:0]      rsp_color_cells,
   input  wire logic                        csr_wr_en,
   input  wire logic [rrch_pkg::COUNT_W-1:0] csr_wr_data
);
   localparam int AW = $clog2(MAX_CELLS);
   localparam int CW = $clog2(MAX_CELLS + 1);
   localparam int TD = (MAX_CELLS > (1 << rrch_pkg::COLOR_W)) ?
                       MAX_CELLS : (1 << rrch_pkg::COLOR_W);
   localparam int TW = $clog2(TD);
   localparam int UW = (CW > TW) ? CW : TW;
   localparam int RESET_N = (rrch_pkg::RESET_CELLS > MAX_CELLS) ?
                            MAX_CELLS : rrch_pkg::RESET_CELLS;

   // Memories.
   logic          mark_mem  [MAX_CELLS];
   logic [AW-1:0] last_mem  [MAX_CELLS];
   logic [TW-1:0] paint_mem [MAX_CELLS];
   logic [CW-1:0] tally_mem [TD];

   logic          mark_we, mark_wd, mark_rd_ff;
   logic [AW-1:0] mark_wa, mark_ra;
   logic          last_we;
   logic [AW-1:0] last_wa, last_ra, last_wd, last_rd_ff;
   logic          paint_we;
   logic [AW-1:0] paint_wa, paint_ra;
   logic [TW-1:0] paint_wd, paint_rd_ff;
   logic          tally_we;
   logic [TW-1:0] tally_wa, tally_ra;
   logic [CW-1:0] tally_wd, tally_rd_ff;

   // Registers.
   rrch_pkg::rrch_state_type state_ff, state_in;
   logic [TW-1:0] clr_ff, clr_in;
   logic [CW-1:0] cells_ff, cells_in;
   logic [TW-1:0] col_ff, col_in, old_ff, old_in;
   logic [AW-1:0] head_ff, head_in, lhead_ff, lhead_in, last_ff, last_in;
   logic [CW-1:0] len_ff, len_in;
   logic [UW-1:0] right_ff, right_in;
   logic          left_ff, left_in;
   logic [AW-1:0] srch_addr_ff, srch_addr_in, srch_q_ff, srch_q_in;
   logic          srch_vld_ff, srch_vld_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [rrch_pkg::COUNT_W-1:0] rsp_data_ff, rsp_data_in;

   // Shared adder.
   rrch_pkg::rrch_alu_op_type alu_op;
   logic [UW-1:0] alu_a, alu_b, alu_res;

   always_comb begin
      unique case (alu_op)
         rrch_pkg::ALU_ADD:    alu_res = alu_a + alu_b;
         rrch_pkg::ALU_SUB:    alu_res = alu_a - alu_b;
         rrch_pkg::ALU_SUBINC: alu_res = alu_a - alu_b + UW'(1);
         rrch_pkg::ALU_DEC:    alu_res = alu_a - UW'(1);
         rrch_pkg::ALU_INC:    alu_res = alu_a + UW'(1);
         default:              alu_res = alu_a;
      endcase
   end

   // Decoded conditions.
   logic [31:0] cell_wide;
   logic        cell_ok, srch_found, clr_last, clr_in_row, clr_in_use, right_ok;
   logic        out_free;
   logic [CW+rrch_pkg::COUNT_W-1:0] cnt_ext;
   assign cell_wide  = 32'(req_cell_req);
   assign cell_ok    = cell_wide < 32'(cells_ff);
   assign srch_found = srch_vld_ff && (mark_rd_ff || (srch_q_ff == '0));
   assign clr_last   = clr_ff == TW'(TD - 1);
   assign clr_in_row = 32'(clr_ff) < 32'(MAX_CELLS);
   assign clr_in_use = 32'(clr_ff) < 32'(cells_ff);
   assign right_ok   = alu_res < UW'(cells_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cnt_ext    = {{rrch_pkg::COUNT_W{1'b0}}, tally_rd_ff};

   // Saturated cell count from a register write; zero acts as one.
   always_comb begin
      cells_in = cells_ff;
      if (csr_wr_en) begin
         if (32'(csr_wr_data) > 32'(MAX_CELLS)) begin
            cells_in = CW'(MAX_CELLS);
         end else if (csr_wr_data == '0) begin
            cells_in = CW'(1);
         end else begin
            cells_in = CW'(csr_wr_data);
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      if (csr_wr_en) begin
         state_in = rrch_pkg::ST_CLEAR;
      end else begin
         unique case (state_ff)
            rrch_pkg::ST_IDLE: begin
               if (req_valid) begin
                  if (req_command == rrch_pkg::CMD_QUERY) begin
                     state_in = rrch_pkg::ST_Q_RD;
                  end else if (cell_ok) begin
                     state_in = rrch_pkg::ST_SRCH;
                  end
               end
            end
            rrch_pkg::ST_CLEAR:    if (clr_last) state_in = rrch_pkg::ST_IDLE;
            rrch_pkg::ST_SRCH: begin
               if (srch_found) begin
                  state_in = left_ff ? rrch_pkg::ST_LEFT_RD : rrch_pkg::ST_HEAD_RD;
               end
            end
            rrch_pkg::ST_HEAD_RD:  state_in = rrch_pkg::ST_HEAD_DAT;
            rrch_pkg::ST_HEAD_DAT: state_in = rrch_pkg::ST_TOLD_RD;
            rrch_pkg::ST_TOLD_RD:  state_in = rrch_pkg::ST_TOLD_WR;
            rrch_pkg::ST_TOLD_WR:  state_in = rrch_pkg::ST_TNEW_RD;
            rrch_pkg::ST_TNEW_RD:  state_in = rrch_pkg::ST_TNEW_WR;
            rrch_pkg::ST_TNEW_WR: begin
               state_in = (head_ff != '0) ? rrch_pkg::ST_SRCH : rrch_pkg::ST_RIGHT_CHK;
            end
            rrch_pkg::ST_LEFT_RD:  state_in = rrch_pkg::ST_LEFT_DAT;
            rrch_pkg::ST_LEFT_DAT: state_in = rrch_pkg::ST_RIGHT_CHK;
            rrch_pkg::ST_RIGHT_CHK: begin
               state_in = right_ok ? rrch_pkg::ST_RIGHT_RD : rrch_pkg::ST_IDLE;
            end
            rrch_pkg::ST_RIGHT_RD:  state_in = rrch_pkg::ST_RIGHT_DAT;
            rrch_pkg::ST_RIGHT_DAT: state_in = rrch_pkg::ST_IDLE;
            rrch_pkg::ST_Q_RD:      state_in = rrch_pkg::ST_Q_DAT;
            rrch_pkg::ST_Q_DAT:     if (out_free) state_in = rrch_pkg::ST_IDLE;
            default:                state_in = rrch_pkg::ST_IDLE;
         endcase
      end
   end

   // Datapath controls and register next values.
   always_comb begin
      mark_we = 1'b0;  mark_wa = clr_ff[AW-1:0]; mark_wd = 1'b1;
      mark_ra = srch_addr_ff;
      last_we = 1'b0;  last_wa = clr_ff[AW-1:0]; last_wd = clr_ff[AW-1:0];
      last_ra = head_ff;
      paint_we = 1'b0; paint_wa = clr_ff[AW-1:0]; paint_wd = clr_ff;
      paint_ra = head_ff;
      tally_we = 1'b0; tally_wa = clr_ff; tally_wd = '0;
      tally_ra = col_ff;
      alu_op = rrch_pkg::ALU_DEC; alu_a = UW'(srch_addr_ff); alu_b = '0;
      clr_in = clr_ff;
      col_in = col_ff; old_in = old_ff; head_in = head_ff; lhead_in = lhead_ff;
      last_in = last_ff; len_in = len_ff; right_in = right_ff; left_in = left_ff;
      srch_addr_in = srch_addr_ff; srch_q_in = srch_q_ff; srch_vld_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      req_stall = state_ff != rrch_pkg::ST_IDLE;
      unique case (state_ff)
         rrch_pkg::ST_IDLE: begin
            if (req_valid) begin
               col_in = TW'(req_color);
               srch_addr_in = cell_wide[AW-1:0];
               left_in = 1'b0;
            end
         end
         rrch_pkg::ST_CLEAR: begin
            mark_we = clr_in_row; last_we = clr_in_row; paint_we = clr_in_row;
            tally_we = 1'b1;
            tally_wd = clr_in_use ? CW'(1) : '0;
            clr_in = clr_ff + TW'(1);
         end
         rrch_pkg::ST_SRCH: begin
            // Walk back one mark a cycle; srch_q_ff holds the address of the mark being read.
            srch_q_in = srch_addr_ff;
            srch_vld_in = !srch_found;
            srch_addr_in = (srch_addr_ff == '0) ? '0 : alu_res[AW-1:0];
            if (srch_found) begin
               if (left_ff) lhead_in = srch_q_ff;
               else head_in = srch_q_ff;
            end
         end
         rrch_pkg::ST_HEAD_RD: ;
         rrch_pkg::ST_HEAD_DAT: begin
            last_in = last_rd_ff;
            old_in = paint_rd_ff;
            alu_op = rrch_pkg::ALU_SUBINC;
            alu_a = UW'(last_rd_ff); alu_b = UW'(head_ff);
            len_in = alu_res[CW-1:0];
         end
         rrch_pkg::ST_TOLD_RD: tally_ra = old_ff;
         rrch_pkg::ST_TOLD_WR: begin
            alu_op = rrch_pkg::ALU_SUB;
            alu_a = UW'(tally_rd_ff); alu_b = UW'(len_ff);
            tally_we = 1'b1; tally_wa = old_ff; tally_wd = alu_res[CW-1:0];
            paint_we = 1'b1; paint_wa = head_ff; paint_wd = col_ff;
         end
         rrch_pkg::ST_TNEW_RD: begin
            alu_op = rrch_pkg::ALU_DEC; alu_a = UW'(head_ff);
            srch_addr_in = alu_res[AW-1:0];
            left_in = 1'b1;
         end
         rrch_pkg::ST_TNEW_WR: begin
            alu_op = rrch_pkg::ALU_ADD;
            alu_a = UW'(tally_rd_ff); alu_b = UW'(len_ff);
            tally_we = 1'b1; tally_wa = col_ff; tally_wd = alu_res[CW-1:0];
         end
         rrch_pkg::ST_LEFT_RD: paint_ra = lhead_ff;
         rrch_pkg::ST_LEFT_DAT: begin
            // Same color on the left: fold this run into that one.
            if (paint_rd_ff == col_ff) begin
               mark_we = 1'b1; mark_wa = head_ff; mark_wd = 1'b0;
               last_we = 1'b1; last_wa = lhead_ff; last_wd = last_ff;
               head_in = lhead_ff;
            end
         end
         rrch_pkg::ST_RIGHT_CHK: begin
            alu_op = rrch_pkg::ALU_INC; alu_a = UW'(last_ff);
            right_in = alu_res;
         end
         rrch_pkg::ST_RIGHT_RD: begin
            paint_ra = right_ff[AW-1:0];
            last_ra = right_ff[AW-1:0];
         end
         rrch_pkg::ST_RIGHT_DAT: begin
            // Same color on the right: absorb that run.
            if (paint_rd_ff == col_ff) begin
               mark_we = 1'b1; mark_wa = right_ff[AW-1:0]; mark_wd = 1'b0;
               last_we = 1'b1; last_wa = head_ff; last_wd = last_rd_ff;
            end
         end
         rrch_pkg::ST_Q_RD: ;
         rrch_pkg::ST_Q_DAT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = cnt_ext[rrch_pkg::COUNT_W-1:0];
            end
         end
         default: ;
      endcase
      if (csr_wr_en) clr_in = '0;
   end

   // Memory ports.
   always_ff @(posedge clock) begin
      if (mark_we) mark_mem[mark_wa] <= mark_wd;
      mark_rd_ff <= mark_mem[mark_ra];
   end
   always_ff @(posedge clock) begin
      if (last_we) last_mem[last_wa] <= last_wd;
      last_rd_ff <= last_mem[last_ra];
   end
   always_ff @(posedge clock) begin
      if (paint_we) paint_mem[paint_wa] <= paint_wd;
      paint_rd_ff <= paint_mem[paint_ra];
   end
   always_ff @(posedge clock) begin
      if (tally_we) tally_mem[tally_wa] <= tally_wd;
      tally_rd_ff <= tally_mem[tally_ra];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrch_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cells_ff     <= CW'(RESET_N);
         rsp_valid_ff <= 1'b0;
         srch_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cells_ff     <= cells_in;
         rsp_valid_ff <= rsp_valid_in;
         srch_vld_ff  <= srch_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      col_ff <= col_in; old_ff <= old_in; head_ff <= head_in; lhead_ff <= lhead_in;
      last_ff <= last_in; len_ff <= len_in; right_ff <= right_in; left_ff <= left_in;
      srch_addr_ff <= srch_addr_in; srch_q_ff <= srch_q_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_color_cells = rsp_data_ff;

   // Checks.
   `RRCH_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (state_ff == rrch_pkg::ST_CLEAR) && (clr_ff == '0))
   `RRCH_ASSERT(a_rsp_from_query, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == rrch_pkg::ST_Q_DAT))
   `RRCH_ASSERT(a_search_stops, clock, reset, (state_ff == rrch_pkg::ST_SRCH) && srch_vld_ff && (srch_q_ff == '0) && !csr_wr_en |=> state_ff != rrch_pkg::ST_SRCH)
   `RRCH_ASSERT(a_run_nonempty, clock, reset, (state_ff == rrch_pkg::ST_TOLD_WR) |-> (len_ff != '0))
endmodule
`default_nettype wire

// ----- test/rrch_checker.sv -----
// Checker for the run repaint color histogram unit: watches both channels,
// keeps its own row of runs and color counts, and compares every count.
// Depends on rrch_pkg.
`timescale 1ns / 1ps
module rrch_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic                         req_command,
   input  logic [rrch_pkg::CELL_W-1:0]  req_cell_req,
   input  logic [rrch_pkg::COLOR_W-1:0] req_color,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [rrch_pkg::COUNT_W-1:0] rsp_color_cells,
   input  logic                         csr_wr_en,
   input  logic [rrch_pkg::COUNT_W-1:0] csr_wr_data,
   output int                           fail_count,
   output int                           pending_counts
);
   localparam int ROW_CELLS   = 1024;
   localparam int CELL_BITS   = rrch_pkg::CELL_W;
   localparam int COLOR_BITS  = rrch_pkg::COLOR_W;
   localparam int COUNT_BITS  = rrch_pkg::COUNT_W;

   logic [COUNT_BITS-1:0] row_cells;
   logic                  start_mark [ROW_CELLS];
   logic [CELL_BITS-1:0]  last_cell [ROW_CELLS];
   logic [COLOR_BITS-1:0] run_color [ROW_CELLS];
   logic [COUNT_BITS-1:0] color_count [ROW_CELLS];
   logic [COUNT_BITS-1:0] expected_counts[$];

   // Rebuild the row with one run per cell; zero acts as one, the top is clamped.
   task automatic restart_row(input logic [COUNT_BITS-1:0] requested);
      int n;
      n = (requested == '0) ? 1 :
          ((int'(requested) > ROW_CELLS) ? ROW_CELLS : int'(requested));
      row_cells = COUNT_BITS'(n);
      for (int i = 0; i < ROW_CELLS; i++) begin
         start_mark[i] = 1'b1;
         last_cell[i] = CELL_BITS'(i);
         run_color[i] = COLOR_BITS'(i);
         color_count[i] = (i < n) ? COUNT_BITS'(1) : '0;
      end
   endtask

   function automatic int find_run_start(input int p);
      while (p > 0 && !start_mark[p]) p--;
      return p;
   endfunction

   // Recolor the run holding the cell, move its length, merge neighbors.
   task automatic repaint_run(input int cell_idx, input logic [COLOR_BITS-1:0] col);
      int head, last, len, left, right;
      if (cell_idx >= int'(row_cells)) return;
      head = find_run_start(cell_idx);
      last = int'(last_cell[head]);
      len = last - head + 1;
      color_count[run_color[head]] = color_count[run_color[head]] - COUNT_BITS'(len);
      color_count[col] = color_count[col] + COUNT_BITS'(len);
      run_color[head] = col;
      if (head > 0) begin
         left = find_run_start(head - 1);
         if (run_color[left] == col) begin
            start_mark[head] = 1'b0;
            last_cell[left] = CELL_BITS'(last);
            head = left;
         end
      end
      right = last + 1;
      if (right < int'(row_cells) && run_color[right] == col) begin
         start_mark[right] = 1'b0;
         last_cell[head] = last_cell[right];
      end
   endtask

   assign pending_counts = expected_counts.size();

   always @(posedge clock) begin
      if (reset) begin
         restart_row(COUNT_BITS'(rrch_pkg::RESET_CELLS));
         expected_counts.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) restart_row(csr_wr_data);
         // Compare a result transfer with the oldest expected count.
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               $display("%0t: unexpected count, expected none, actual %0d",
                        $time, rsp_color_cells);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_color_cells !== expected_counts[0]) begin
                  $display("%0t: color_cells mismatch, expected %0d, actual %0d",
                           $time, expected_counts[0], rsp_color_cells);
                  fail_count <= fail_count + 1;
               end
               void'(expected_counts.pop_front());
            end
         end
         // Apply a command transfer to the model row.
         if (req_valid && !req_stall) begin
            if (req_command == rrch_pkg::CMD_PAINT) repaint_run(int'(req_cell_req), req_color);
            else expected_counts.push_back(color_count[req_color]);
         end
      end
   end
endmodule

// ----- test/tb_run_repaint_color_histogram_unit.sv -----
// Testbench top for the run repaint color histogram unit: clock, reset,
// command and cell-count stimulus, receiver stalls and the verdict.
// Depends on rrch_pkg, rrch_checker and the unit itself.
`timescale 1ns / 1ps
module tb_run_repaint_color_histogram_unit;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int CELL_BITS   = rrch_pkg::CELL_W;
   localparam int COLOR_BITS  = rrch_pkg::COLOR_W;
   localparam int COUNT_BITS  = rrch_pkg::COUNT_W;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_command = rrch_pkg::CMD_PAINT;
   logic [CELL_BITS-1:0]  req_cell_req = '0;
   logic [COLOR_BITS-1:0] req_color = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [COUNT_BITS-1:0] rsp_color_cells;
   logic                  csr_wr_en = 1'b0;
   logic [COUNT_BITS-1:0] csr_wr_data = '0;
   int                    fail_count;
   int                    pending_counts;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   bit                    hold_off_now = 1'b0;
   int                    cycle_count = 0;
   int                    row_now = 1024;

   always #5 clock = ~clock;

   run_repaint_color_histogram_unit dut (.*);

   rrch_checker checker_inst (.*);

   // The receiver stalls at random, or solidly during the long hold-off.
   always @(posedge clock) begin
      rsp_stall <= hold_off_now || ($urandom_range(99) < recv_idle_pct);
   end

   // Cycle limit for the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offer one command and hold it until req_stall is low; valid stays up after it.
   task automatic send_command(input logic cmd, input int cell_idx, input int col);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_cell_req <= CELL_BITS'(cell_idx);
      req_color <= COLOR_BITS'(col);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Wait for every count, let a trailing paint finish, then set the row size.
   task automatic write_cell_count(input int value);
      req_valid <= 1'b0;
      while (pending_counts != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= COUNT_BITS'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      row_now = (value == 0) ? 1 : (value > 1024 ? 1024 : value);
   endtask

   // Mostly paints of cells in the row with a small working set of colors, some queries.
   task automatic random_commands(input int count);
      int col_span;
      for (int k = 0; k < count; k++) begin
         col_span = ($urandom_range(3) == 0) ? 1023 : 7;
         if ($urandom_range(2) == 0)
            send_command(rrch_pkg::CMD_QUERY, $urandom_range(1023),
                         $urandom_range(col_span));
         else if ($urandom_range(15) == 0)
            send_command(rrch_pkg::CMD_PAINT, $urandom_range(1023), $urandom_range(1023));
         else
            send_command(rrch_pkg::CMD_PAINT, $urandom_range(row_now - 1),
                         $urandom_range(col_span));
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: edges of the row, merges, out-of-row paint, unused colors.
      send_command(rrch_pkg::CMD_QUERY, 0, 0);
      send_command(rrch_pkg::CMD_QUERY, 1023, 1023);
      send_command(rrch_pkg::CMD_PAINT, 1, 0);
      send_command(rrch_pkg::CMD_PAINT, 2, 0);
      send_command(rrch_pkg::CMD_QUERY, 0, 0);
      send_command(rrch_pkg::CMD_PAINT, 1023, 1022);
      send_command(rrch_pkg::CMD_QUERY, 0, 1022);
      send_command(rrch_pkg::CMD_PAINT, 1, 1023);
      send_command(rrch_pkg::CMD_QUERY, 0, 1023);
      send_command(rrch_pkg::CMD_PAINT, 512, 341);
      send_command(rrch_pkg::CMD_PAINT, 513, 682);
      send_command(rrch_pkg::CMD_QUERY, 0, 682);
      write_cell_count(0);
      send_command(rrch_pkg::CMD_PAINT, 1, 5);
      send_command(rrch_pkg::CMD_PAINT, 0, 5);
      send_command(rrch_pkg::CMD_QUERY, 0, 5);
      send_command(rrch_pkg::CMD_QUERY, 0, 0);
      write_cell_count(2047);
      send_command(rrch_pkg::CMD_QUERY, 0, 1023);
      write_cell_count(6);
      send_command(rrch_pkg::CMD_PAINT, 5, 0);
      send_command(rrch_pkg::CMD_PAINT, 6, 0);
      send_command(rrch_pkg::CMD_QUERY, 0, 5);
      send_command(rrch_pkg::CMD_QUERY, 0, 0);

      send_idle_pct = 6;
      recv_idle_pct = 82;
      random_commands(380);
      write_cell_count(1);
      random_commands(60);
      write_cell_count(37);
      send_idle_pct = 82;
      recv_idle_pct = 6;
      random_commands(400);
      write_cell_count(1024);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_commands(300);

      // Long receiver hold-off while commands keep coming.
      write_cell_count(200);
      fork
         begin
            hold_off_now = 1'b1;
            repeat (2000) @(posedge clock);
            hold_off_now = 1'b0;
         end
         random_commands(400);
      join
      req_valid <= 1'b0;

      while (pending_counts != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ----- files.f -----
+incdir+sv
sv/rrch_pkg.sv
sv/run_repaint_color_histogram_unit.sv
test/rrch_checker.sv
test/tb_run_repaint_color_histogram_unit.sv
